>>> rtl/core/keyed_table_linear_interpolator_assert.svh
// assertion macros for the keyed table interpolator
`ifndef KEYED_TABLE_LINEAR_INTERPOLATOR_ASSERT_SVH
`define KEYED_TABLE_LINEAR_INTERPOLATOR_ASSERT_SVH

// same-cycle implication
`define KTI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KTI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/kti_pkg.sv
// shared types and constants of the keyed table interpolator
package kti_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  localparam int IDX_W   = 6;
  localparam int POWER_W = 14;
  localparam int MAT_W   = 8;
  localparam int GAS_W   = 4;
  localparam int KEY_W   = 27;
  localparam int THICK_W = 16;
  localparam int SPEED_W = 17;
  localparam int PIER_W  = 16;
  localparam int CFG_W   = 16;
  localparam int STAT_W  = 2;
  localparam int MAG_W   = 33;
  localparam int DSTEP_W = 5;

  localparam logic [CFG_W-1:0] DEF_PIERCE_RST = 16'd250;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [STAT_W-1:0] MS_NONE    = 2'd0;
  localparam logic [STAT_W-1:0] MS_EXACT   = 2'd1;
  localparam logic [STAT_W-1:0] MS_NEAREST = 2'd2;
  localparam logic [STAT_W-1:0] MS_INTERP  = 2'd3;

  localparam logic [1:0] VSEL_MIN    = 2'd0;
  localparam logic [1:0] VSEL_MAX    = 2'd1;
  localparam logic [1:0] VSEL_NOM    = 2'd2;
  localparam logic [1:0] VSEL_PIERCE = 2'd3;

  typedef struct packed {
    logic [PIER_W-1:0]  pierce;
    logic [SPEED_W-1:0] spd_nom;
    logic [SPEED_W-1:0] spd_max;
    logic [SPEED_W-1:0] spd_min;
    logic [THICK_W-1:0] thick;
    logic [KEY_W-1:0]   key;
  } entry_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_PICK, S_MUL, S_DIV, S_DWAIT, S_LOAD
  } state_t;

  typedef struct packed {
    logic       mem_clear;
    logic       mem_write;
    logic       query_cap;
    logic       rd_en;
    logic       mul_ld;
    logic       div_start;
    logic       res_st;
    logic       out_ld;
    logic [1:0] val_sel;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic have_n;
    logic do_interp;
    logic div_busy;
    logic out_hold;
  } status_t;

endpackage

>>> rtl/core/keyed_table_linear_interpolator.sv
// keyed cutting table with nearest lookup and linear interpolation, top level
// After reset the block clears the table valid marks, one slot per cycle, through
// every slot before taking items. A query reads every slot once through the
// table ram's single read port; an interpolated answer then adds four passes
// through the shared multiplier and divider. A finished result waits in an
// output register while the next item is accepted.
module keyed_table_linear_interpolator #(
  parameter int TABLE_DEPTH = kti_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kti_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          opcode,
  input  logic [kti_pkg::IDX_W-1:0]     entry_index,
  input  logic [kti_pkg::POWER_W-1:0]   power_code,
  input  logic [kti_pkg::MAT_W-1:0]     material_id,
  input  logic [kti_pkg::GAS_W-1:0]     gas_id,
  input  logic [kti_pkg::THICK_W-1:0]   thickness,
  input  logic [kti_pkg::SPEED_W-1:0]   speed_min_in,
  input  logic [kti_pkg::SPEED_W-1:0]   speed_max_in,
  input  logic [kti_pkg::SPEED_W-1:0]   speed_nominal_in,
  input  logic [kti_pkg::PIER_W-1:0]    pierce_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [kti_pkg::STAT_W-1:0]    match_status,
  output logic [kti_pkg::THICK_W-1:0]   thickness_out,
  output logic [kti_pkg::SPEED_W-1:0]   speed_min_out,
  output logic [kti_pkg::SPEED_W-1:0]   speed_max_out,
  output logic [kti_pkg::SPEED_W-1:0]   speed_nominal_out,
  output logic [kti_pkg::PIER_W-1:0]    pierce_out
);
  import kti_pkg::*;

  cmd_t                       cmd;
  status_t                    stat;
  logic [$clog2(TABLE_DEPTH)-1:0] cnt_addr;

  assign cfg_ready = 1'b1;

  kti_ctrl #(.DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd),
    .cnt_addr (cnt_addr)
  );

  kti_dp #(.DEPTH(TABLE_DEPTH)) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .cnt_addr          (cnt_addr),
    .stat              (stat),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_data          (cfg_data),
    .opcode            (opcode),
    .entry_index       (entry_index),
    .power_code        (power_code),
    .material_id       (material_id),
    .gas_id            (gas_id),
    .thickness         (thickness),
    .speed_min_in      (speed_min_in),
    .speed_max_in      (speed_max_in),
    .speed_nominal_in  (speed_nominal_in),
    .pierce_in         (pierce_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .match_status      (match_status),
    .thickness_out     (thickness_out),
    .speed_min_out     (speed_min_out),
    .speed_max_out     (speed_max_out),
    .speed_nominal_out (speed_nominal_out),
    .pierce_out        (pierce_out)
  );

endmodule

>>> rtl/core/kti_ram.sv
// generic single write port ram with registered read
module kti_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/kti_div.sv
// iterative restoring divider, one quotient bit per cycle
module kti_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [kti_pkg::MAG_W-1:0]   dividend,
  input  logic [kti_pkg::THICK_W-1:0] divisor,
  output logic                       busy,
  output logic [kti_pkg::SPEED_W-1:0] quotient
);
  import kti_pkg::*;

  logic [THICK_W-1:0] rem;
  logic [SPEED_W-1:0] qs;
  logic [DSTEP_W-1:0] steps;
  logic [THICK_W:0]   trial;
  logic               ge;

  assign trial = {rem, qs[SPEED_W-1]};
  assign ge = trial >= {1'b0, divisor};
  assign quotient = qs;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= DSTEP_W'(SPEED_W);
    end else if (busy) begin
      steps <= steps - 1'b1;
      busy  <= steps != DSTEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[MAG_W-1:SPEED_W];
      qs  <= dividend[SPEED_W-1:0];
    end else if (busy) begin
      rem <= ge ? THICK_W'(trial - {1'b0, divisor}) : trial[THICK_W-1:0];
      qs  <= {qs[SPEED_W-2:0], ge};
    end
  end

endmodule

>>> rtl/core/kti_dp.sv
// datapath: table ram, scan compare, interpolation and result register
module kti_dp #(
  parameter int DEPTH = kti_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  kti_pkg::cmd_t                 cmd,
  input  logic [$clog2(DEPTH)-1:0]      cnt_addr,
  output kti_pkg::status_t              stat,
  input  logic                          cfg_we,
  input  logic [kti_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          opcode,
  input  logic [kti_pkg::IDX_W-1:0]     entry_index,
  input  logic [kti_pkg::POWER_W-1:0]   power_code,
  input  logic [kti_pkg::MAT_W-1:0]     material_id,
  input  logic [kti_pkg::GAS_W-1:0]     gas_id,
  input  logic [kti_pkg::THICK_W-1:0]   thickness,
  input  logic [kti_pkg::SPEED_W-1:0]   speed_min_in,
  input  logic [kti_pkg::SPEED_W-1:0]   speed_max_in,
  input  logic [kti_pkg::SPEED_W-1:0]   speed_nominal_in,
  input  logic [kti_pkg::PIER_W-1:0]    pierce_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [kti_pkg::STAT_W-1:0]    match_status,
  output logic [kti_pkg::THICK_W-1:0]   thickness_out,
  output logic [kti_pkg::SPEED_W-1:0]   speed_min_out,
  output logic [kti_pkg::SPEED_W-1:0]   speed_max_out,
  output logic [kti_pkg::SPEED_W-1:0]   speed_nominal_out,
  output logic [kti_pkg::PIER_W-1:0]    pierce_out
);
  import kti_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [CFG_W-1:0]   def_pierce;
  logic [KEY_W-1:0]   key_q;
  logic [THICK_W-1:0] q_thick;

  // write normalization
  logic [SPEED_W:0]   spd_sum;
  logic [SPEED_W-1:0] w_nom, w_max, w_min;
  logic [PIER_W-1:0]  w_pier;
  entry_t             w_entry, wdata, rdata;
  logic [31:0]        idx_ext;
  logic               idx_ok, ram_we;
  logic [AW-1:0]      waddr;

  assign spd_sum = {1'b0, speed_min_in} + {1'b0, speed_max_in};
  assign w_nom   = (speed_nominal_in == '0) ? spd_sum[SPEED_W:1] : speed_nominal_in;
  assign w_max   = (speed_max_in == '0) ? w_nom : speed_max_in;
  assign w_min   = (speed_min_in == '0) ? w_nom : speed_min_in;
  assign w_pier  = (pierce_in == '0) ? def_pierce : pierce_in;
  assign idx_ext = 32'(entry_index);
  assign idx_ok  = idx_ext < 32'(DEPTH);

  always_comb begin
    w_entry.pierce  = w_pier;
    w_entry.spd_nom = w_nom;
    w_entry.spd_max = w_max;
    w_entry.spd_min = w_min;
    w_entry.thick   = thickness;
    w_entry.key     = {(thickness != '0) && (w_nom != '0), gas_id, material_id, power_code};
  end

  assign ram_we = cmd.mem_clear || (cmd.mem_write && idx_ok);
  assign waddr  = cmd.mem_clear ? cnt_addr : idx_ext[AW-1:0];
  assign wdata  = cmd.mem_clear ? '0 : w_entry;

  kti_ram #(.WIDTH($bits(entry_t)), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (cnt_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      def_pierce <= DEF_PIERCE_RST;
    end else if (cfg_we) begin
      def_pierce <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query_cap) begin
      key_q   <= {1'b1, gas_id, material_id, power_code};
      q_thick <= thickness;
    end
  end

  // scan
  logic               ev_vld, have_n, have_l, have_u;
  entry_t             ent_n, ent_l, ent_u;
  logic [THICK_W-1:0] best, gap;
  logic               hit, upd_n, upd_l, upd_u;

  assign hit   = ev_vld && (rdata.key == key_q);
  assign gap   = (rdata.thick > q_thick) ? rdata.thick - q_thick : q_thick - rdata.thick;
  assign upd_n = hit && (!have_n || gap < best);
  assign upd_l = hit && (rdata.thick <= q_thick) && (!have_l || rdata.thick > ent_l.thick);
  assign upd_u = hit && (rdata.thick >= q_thick) && (!have_u || rdata.thick < ent_u.thick);

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_vld <= 1'b0;
      have_n <= 1'b0;
      have_l <= 1'b0;
      have_u <= 1'b0;
    end else begin
      ev_vld <= cmd.rd_en;
      if (cmd.query_cap) begin
        have_n <= 1'b0;
        have_l <= 1'b0;
        have_u <= 1'b0;
      end else begin
        have_n <= have_n || upd_n;
        have_l <= have_l || upd_l;
        have_u <= have_u || upd_u;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_n) begin
      ent_n <= rdata;
      best  <= gap;
    end
    if (upd_l) begin
      ent_l <= rdata;
    end
    if (upd_u) begin
      ent_u <= rdata;
    end
  end

  // interpolation
  logic [SPEED_W-1:0] v_lo, v_hi, lo_q, quo;
  logic [SPEED_W:0]   diff, adiff;
  logic               neg_q;
  logic [THICK_W-1:0] num, den;
  logic [MAG_W-1:0]   mag;
  logic [SPEED_W-1:0] res [4];
  logic               div_busy;
  logic [SPEED_W:0]   sum;

  always_comb begin
    unique case (cmd.val_sel)
      VSEL_MIN: begin
        v_lo = ent_l.spd_min;
        v_hi = ent_u.spd_min;
      end
      VSEL_MAX: begin
        v_lo = ent_l.spd_max;
        v_hi = ent_u.spd_max;
      end
      VSEL_NOM: begin
        v_lo = ent_l.spd_nom;
        v_hi = ent_u.spd_nom;
      end
      default: begin
        v_lo = SPEED_W'(ent_l.pierce);
        v_hi = SPEED_W'(ent_u.pierce);
      end
    endcase
  end

  assign diff  = {1'b0, v_hi} - {1'b0, v_lo};
  assign adiff = diff[SPEED_W] ? -diff : diff;
  assign num   = q_thick - ent_l.thick;
  assign den   = ent_u.thick - ent_l.thick;

  always_ff @(posedge clk) begin
    if (cmd.mul_ld) begin
      mag   <= MAG_W'(adiff[SPEED_W-1:0] * num);
      neg_q <= diff[SPEED_W];
      lo_q  <= v_lo;
    end
  end

  kti_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (mag),
    .divisor  (den),
    .busy     (div_busy),
    .quotient (quo)
  );

  assign sum = neg_q ? {1'b0, lo_q} - {1'b0, quo} : {1'b0, lo_q} + {1'b0, quo};

  always_ff @(posedge clk) begin
    if (cmd.res_st) begin
      res[cmd.val_sel] <= sum[SPEED_W-1:0];
    end
  end

  // result register
  logic interp;

  assign interp = have_l && have_u && (ent_u.thick > ent_l.thick);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      if (!have_n) begin
        match_status      <= MS_NONE;
        thickness_out     <= '0;
        speed_min_out     <= '0;
        speed_max_out     <= '0;
        speed_nominal_out <= '0;
        pierce_out        <= '0;
      end else if (interp) begin
        match_status      <= MS_INTERP;
        thickness_out     <= q_thick;
        speed_min_out     <= res[VSEL_MIN];
        speed_max_out     <= res[VSEL_MAX];
        speed_nominal_out <= res[VSEL_NOM];
        pierce_out        <= res[VSEL_PIERCE][PIER_W-1:0];
      end else begin
        match_status      <= (ent_n.thick == q_thick) ? MS_EXACT : MS_NEAREST;
        thickness_out     <= ent_n.thick;
        speed_min_out     <= ent_n.spd_min;
        speed_max_out     <= ent_n.spd_max;
        speed_nominal_out <= ent_n.spd_nom;
        pierce_out        <= ent_n.pierce;
      end
    end
  end

  always_comb begin
    stat.is_query  = opcode == OP_QUERY;
    stat.have_n    = have_n;
    stat.do_interp = interp;
    stat.div_busy  = div_busy;
    stat.out_hold  = out_valid && out_stall;
  end

endmodule

>>> rtl/core/kti_ctrl.sv
// controller: clearing pass, scan sequencing and interpolation steps
module kti_ctrl #(
  parameter int DEPTH = kti_pkg::TABLE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  kti_pkg::status_t         stat,
  output kti_pkg::cmd_t            cmd,
  output logic [$clog2(DEPTH)-1:0] cnt_addr
);
  import kti_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] CNT_LAST = CW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_END  = CW'(DEPTH);

  state_t        state, state_next;
  logic [CW-1:0] cnt;
  logic [1:0]    vsel;
  logic          in_acc;

  assign in_acc   = in_valid && !in_stall;
  assign cnt_addr = cnt[AW-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (cnt == CNT_LAST) state_next = S_IDLE;
      S_IDLE:  if (in_acc && stat.is_query) state_next = S_SCAN;
      S_SCAN:  if (cnt == CNT_END) state_next = S_PICK;
      S_PICK:  state_next = stat.have_n && stat.do_interp ? S_MUL : S_LOAD;
      S_MUL:   state_next = S_DIV;
      S_DIV:   state_next = S_DWAIT;
      S_DWAIT: begin
        if (!stat.div_busy) begin
          state_next = (vsel == VSEL_PIERCE) ? S_LOAD : S_MUL;
        end
      end
      S_LOAD:  if (!stat.out_hold) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    in_stall      = state != S_IDLE;
    cmd           = '0;
    cmd.val_sel   = vsel;
    cmd.mem_clear = state == S_CLEAR;
    cmd.mem_write = (state == S_IDLE) && in_valid && !stat.is_query;
    cmd.query_cap = (state == S_IDLE) && in_valid && stat.is_query;
    cmd.rd_en     = (state == S_SCAN) && (cnt != CNT_END);
    cmd.mul_ld    = state == S_MUL;
    cmd.div_start = state == S_DIV;
    cmd.res_st    = (state == S_DWAIT) && !stat.div_busy;
    cmd.out_ld    = (state == S_LOAD) && !stat.out_hold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt   <= '0;
      vsel  <= VSEL_MIN;
    end else begin
      state <= state_next;
      unique case (state)
        S_CLEAR: cnt <= cnt + 1'b1;
        S_IDLE:  cnt <= '0;
        S_SCAN:  if (cnt != CNT_END) cnt <= cnt + 1'b1;
        default: cnt <= cnt;
      endcase
      if (state == S_PICK) begin
        vsel <= VSEL_MIN;
      end else if (cmd.res_st && vsel != VSEL_PIERCE) begin
        vsel <= vsel + 1'b1;
      end
    end
  end

`include "keyed_table_linear_interpolator_assert.svh"

  `KTI_ASSERT_NOW(a_load_no_overwrite, cmd.out_ld, !stat.out_hold, "result overwritten")
  `KTI_ASSERT_NOW(a_div_idle_start, cmd.div_start, !stat.div_busy, "divider restarted")
  `KTI_ASSERT_NEXT(a_query_scans, cmd.query_cap, state == S_SCAN && cnt == '0,
                   "query did not start scan")
  `KTI_ASSERT_NOW(a_scan_addr_range, cmd.rd_en || cmd.mem_clear, cnt < CNT_END,
                  "table address out of range")

endmodule
